FILE: design/irc_message_tokenizer_macros.svh
// Assertion macros shared by the tokenizer's checking code.
`ifndef IRC_MESSAGE_TOKENIZER_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRCTOK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRCTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/irctok_pkg.sv
// Types, constants and codes shared by the IRC line tokenizer modules.
package irctok_pkg;

    localparam int MAX_LEN_DEF = 512;
    localparam int FIELD_W     = 9;
    localparam int KIND_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // field kinds as they appear on the result channel
    localparam logic [KIND_W-1:0] KIND_NICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_USER    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HOST    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARAM   = 3'd4;

    localparam logic [FIELD_W-1:0] PARAM_MAX = {FIELD_W{1'b1}};

    // what the back end does with the open-field offset
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_OPEN_HERE,
        ACT_OPEN_NEXT,
        ACT_CLOSE
    } tok_act_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               field_valid;
        logic [KIND_W-1:0]  field_kind;
        logic [FIELD_W-1:0] field_start;
        logic [FIELD_W-1:0] field_length;
        logic [FIELD_W-1:0] param_number;
        logic               message_done;
        logic               message_ok;
        logic               parse_error;
    } out_item_t;

    // classified step handed from front to back
    typedef struct packed {
        tok_act_t           act;
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] pos;
        logic               last;
        logic               ok;
        logic               err;
    } tok_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: design/irctok_front.sv
// Front end: byte classification, line state machine and position tracking.
module irctok_front #(
    parameter int MAX_LEN = irctok_pkg::MAX_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  irctok_pkg::in_item_t  s_item,
    input  irctok_pkg::q_status_t q_status,
    output logic                  push,
    output irctok_pkg::tok_entry_t push_entry
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        C_NUL, C_LF, C_CR, C_SP, C_BANG, C_COLON, C_AT, C_ETC
    } cls_t;

    typedef enum logic [4:0] {
        P_BEGIN, P_NICK0, P_NICK, P_NICKSP, P_USER0, P_USER, P_USERSP,
        P_HOST0, P_HOST, P_HOSTSP, P_PFXSP, P_CMD0, P_CMD, P_CMDSP,
        P_ARG0, P_ARG, P_ARGSP, P_TRAIL0, P_TRAIL, P_CRSP, P_CRARG, P_LF,
        P_ERR
    } pstate_t;

    pstate_t            state_reg, state_next, nxt;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W+8:0]   pos_wide;
    cls_t               cls;
    logic               over;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        case (b)
            8'h00:   c = C_NUL;
            8'h0A:   c = C_LF;
            8'h0D:   c = C_CR;
            8'h20:   c = C_SP;
            8'h21:   c = C_BANG;
            8'h3A:   c = C_COLON;
            8'h40:   c = C_AT;
            default: c = C_ETC;
        endcase
        return c;
    endfunction

    function automatic pstate_t step(input pstate_t s, input cls_t c);
        pstate_t n;
        logic    printable;
        printable = (c == C_BANG) || (c == C_COLON) || (c == C_AT) || (c == C_ETC);
        n = P_ERR;
        case (s)
            P_BEGIN: begin
                if (c == C_COLON) n = P_NICK0;
                else if (c == C_ETC) n = P_CMD0;
            end
            P_NICK0: if (c == C_ETC) n = P_NICK;
            P_NICK: begin
                if (c == C_SP) n = P_NICKSP;
                else if (c == C_BANG) n = P_USER0;
                else if (c == C_AT) n = P_HOST0;
                else if (c == C_ETC) n = P_NICK;
            end
            P_NICKSP, P_USERSP, P_HOSTSP, P_PFXSP: begin
                if (c == C_SP) n = P_PFXSP;
                else if (c == C_ETC) n = P_CMD0;
            end
            P_USER0: if (c == C_ETC) n = P_USER;
            P_USER: begin
                if (c == C_SP) n = P_USERSP;
                else if (c == C_AT) n = P_HOST0;
                else if (c == C_ETC) n = P_USER;
            end
            P_HOST0: if (c == C_COLON || c == C_ETC) n = P_HOST;
            P_HOST: begin
                if (c == C_SP) n = P_HOSTSP;
                else if (c == C_COLON || c == C_ETC) n = P_HOST;
            end
            P_CMD0, P_CMD: begin
                if (c == C_SP) n = P_CMDSP;
                else if (c == C_ETC) n = P_CMD;
            end
            P_CMDSP: begin
                if (c == C_SP) n = P_CMDSP;
                else if (c == C_COLON) n = P_TRAIL0;
                else if (printable) n = P_ARG0;
            end
            P_ARG0: begin
                if (c == C_SP) n = P_ARGSP;
                else if (printable) n = P_ARG;
            end
            P_ARG: begin
                if (c == C_CR) n = P_CRARG;
                else if (c == C_SP) n = P_ARGSP;
                else if (printable) n = P_ARG;
            end
            P_ARGSP: begin
                if (c == C_CR) n = P_CRSP;
                else if (c == C_SP) n = P_ARGSP;
                else if (c == C_COLON) n = P_TRAIL0;
                else if (printable) n = P_ARG0;
            end
            P_TRAIL0, P_TRAIL: begin
                if (c == C_CR) n = P_CRARG;
                else if (c == C_SP || printable) n = P_TRAIL;
            end
            P_CRSP, P_CRARG: if (c == C_LF) n = P_LF;
            default: n = P_ERR;
        endcase
        return n;
    endfunction

    assign s_ready  = !q_status.full;
    assign push     = s_valid && s_ready;
    assign cls      = classify(s_item.data_byte);
    assign over     = (pos_reg >= POS_W'(MAX_LEN));
    assign nxt      = (state_reg == P_ERR || over) ? P_ERR : step(state_reg, cls);
    assign pos_wide = {9'd0, pos_reg};

    // field events of this byte
    always_comb begin
        push_entry      = '0;
        push_entry.act  = irctok_pkg::ACT_NONE;
        push_entry.kind = irctok_pkg::KIND_NICK;
        push_entry.pos  = pos_wide[irctok_pkg::FIELD_W-1:0];
        push_entry.last = s_item.last_byte;
        push_entry.ok   = s_item.last_byte && (nxt == P_LF);
        push_entry.err  = (nxt == P_ERR);
        case (nxt)
            P_NICK0, P_TRAIL0: push_entry.act = irctok_pkg::ACT_OPEN_NEXT;
            P_CMD0, P_ARG0:    push_entry.act = irctok_pkg::ACT_OPEN_HERE;
            P_USER0, P_NICKSP: push_entry.act = irctok_pkg::ACT_CLOSE;
            P_USERSP: begin
                push_entry.act  = irctok_pkg::ACT_CLOSE;
                push_entry.kind = irctok_pkg::KIND_USER;
            end
            P_HOST0: begin
                push_entry.act  = irctok_pkg::ACT_CLOSE;
                push_entry.kind = (state_reg == P_NICK) ? irctok_pkg::KIND_NICK
                                                        : irctok_pkg::KIND_USER;
            end
            P_HOSTSP: begin
                push_entry.act  = irctok_pkg::ACT_CLOSE;
                push_entry.kind = irctok_pkg::KIND_HOST;
            end
            P_CMDSP: begin
                if (state_reg != P_CMDSP) push_entry.act = irctok_pkg::ACT_CLOSE;
                push_entry.kind = irctok_pkg::KIND_COMMAND;
            end
            P_ARGSP: begin
                if (state_reg != P_ARGSP) push_entry.act = irctok_pkg::ACT_CLOSE;
                push_entry.kind = irctok_pkg::KIND_PARAM;
            end
            P_CRARG: begin
                push_entry.act  = irctok_pkg::ACT_CLOSE;
                push_entry.kind = irctok_pkg::KIND_PARAM;
            end
            default: push_entry.act = irctok_pkg::ACT_NONE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        if (push) begin
            if (s_item.last_byte) begin
                state_next = P_BEGIN;
                pos_next   = '0;
            end else begin
                state_next = nxt;
                if (!over) pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_BEGIN;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: design/irctok_queue.sv
// Short FIFO of classified steps between front and back.
module irctok_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  irctok_pkg::tok_entry_t push_entry,
    input  logic                   pop,
    output irctok_pkg::tok_entry_t head,
    output irctok_pkg::q_status_t  status
);

    irctok_pkg::tok_entry_t            slot_reg [irctok_pkg::QUEUE_DEPTH];
    logic [irctok_pkg::QPTR_W-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [irctok_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign head         = slot_reg[rd_reg];
    assign status.full  = (cnt_reg == irctok_pkg::QCNT_W'(irctok_pkg::QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)      cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/irctok_back.sv
// Back end: field offsets, lengths, parameter numbering and output register.
module irctok_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  irctok_pkg::tok_entry_t head,
    input  irctok_pkg::q_status_t  q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output irctok_pkg::out_item_t  m_item
);

    logic [irctok_pkg::FIELD_W-1:0] ofs_reg, ofs_next, pc_reg, pc_next, pc_inc;
    logic                           m_valid_reg, m_valid_next;
    irctok_pkg::out_item_t          m_item_reg, m_item_next;
    logic                           is_param;

    assign pop      = !q_status.empty && (!m_valid_reg || m_ready);
    assign is_param = (head.kind == irctok_pkg::KIND_PARAM);
    assign pc_inc   = (pc_reg == irctok_pkg::PARAM_MAX) ? pc_reg : pc_reg + 1'b1;

    always_comb begin
        ofs_next     = ofs_reg;
        pc_next      = pc_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pop) begin
            m_valid_next             = 1'b1;
            m_item_next              = '0;
            m_item_next.message_done = head.last;
            m_item_next.message_ok   = head.ok;
            m_item_next.parse_error  = head.err;
            case (head.act)
                irctok_pkg::ACT_OPEN_HERE: ofs_next = head.pos;
                irctok_pkg::ACT_OPEN_NEXT: ofs_next = head.pos + 1'b1;
                irctok_pkg::ACT_CLOSE: begin
                    m_item_next.field_valid  = 1'b1;
                    m_item_next.field_kind   = head.kind;
                    m_item_next.field_start  = ofs_reg;
                    m_item_next.field_length = head.pos - ofs_reg;
                    if (is_param) begin
                        pc_next                  = pc_inc;
                        m_item_next.param_number = pc_inc;
                    end
                    if (head.kind == irctok_pkg::KIND_NICK
                            || head.kind == irctok_pkg::KIND_USER) begin
                        ofs_next = head.pos + 1'b1;
                    end
                end
                default: ofs_next = ofs_reg;
            endcase
            if (head.last) begin
                ofs_next = '0;
                pc_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ofs_reg     <= '0;
            pc_reg      <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            ofs_reg     <= ofs_next;
            pc_reg      <= pc_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: design/irc_message_tokenizer.sv
// Top level of the IRC message line tokenizer.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   in_item_t  : data_byte, last_byte
//  m_       out        m_valid / m_ready   out_item_t : one result per byte
//
// One byte per clock while the queue has room: the front steps the line
// state machine in the accepting cycle and pushes the step into the queue;
// the back pops it into the result register, which drives m_valid, and the
// result leaves on the m_valid / m_ready handshake.
// Reset (aresetn low, synchronous) empties the queue and returns the parser
// to the start of a line; the last byte of a line also restarts the parser.
// A stalled result side fills the four-entry queue; s_ready drops only then.
`include "irc_message_tokenizer_macros.svh"

module irc_message_tokenizer #(
    parameter int MAX_LEN = irctok_pkg::MAX_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  irctok_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output irctok_pkg::out_item_t m_item
);

    logic                   push, pop;
    irctok_pkg::tok_entry_t push_entry, head;
    irctok_pkg::q_status_t  q_status;
    logic                   q_bad, ok_clean, field_clear, pnum_match;

    // classify and step the state machine
    irctok_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples the two ends
    irctok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // offsets, lengths, parameter count, result register
    irctok_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // terms for the checks below
    assign q_bad       = q_status.full && q_status.empty;
    assign ok_clean    = !m_item.message_ok
                         || (m_item.message_done && !m_item.parse_error
                             && !m_item.field_valid);
    assign field_clear = m_item.field_valid
                         || ((m_item.field_kind == '0) && (m_item.field_start == '0)
                             && (m_item.field_length == '0)
                             && (m_item.param_number == '0));
    assign pnum_match  = !m_item.field_valid
                         || ((m_item.param_number != '0)
                             == (m_item.field_kind == irctok_pkg::KIND_PARAM));

    `IRCTOK_ASSERT_NOW(a_queue_sane, aclk, aresetn, 1'b1, !q_bad, "queue both full and empty")
    `IRCTOK_ASSERT_NOW(a_ok_clean, aclk, aresetn, m_valid, ok_clean, "ok without clean done")
    `IRCTOK_ASSERT_NOW(a_no_field_zero, aclk, aresetn, m_valid, field_clear, "stale field data")
    `IRCTOK_ASSERT_NOW(a_param_num, aclk, aresetn, m_valid, pnum_match, "parameter number mismatch")
    `IRCTOK_ASSERT_NEXT(a_pop_fills, aclk, aresetn, pop, m_valid, "popped step gave no result")

endmodule

FILE: bench/irc_message_tokenizer_tb.sv
// Self-checking bench for the IRC line tokenizer: random byte lines vs. a line-parser predictor.
`timescale 1ns / 100ps

module irc_message_tokenizer_tb;

    // Line length limit, passed to the block so both sides agree.
    localparam int LINE_MAX       = irctok_pkg::MAX_LEN_DEF;
    // Short random items; the overlong line comes on top of these.
    localparam int RANDOM_ITEMS   = 300;
    // Results seen before the receiver's long hold-off kicks in.
    localparam int HOLDOFF_AFTER  = 150;
    localparam int HOLDOFF_CYCLES = 64;
    // Drain time after the last owed report; ample for stragglers.
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 200000;
    // Parameters in the long line: enough to push offsets past 256.
    localparam int LONG_PARAMS    = 150;

    // Byte values with a meaning to the parser.
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_BANG  = 8'h21;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_AT    = 8'h40;

    typedef enum logic [2:0] {
        CL_NUL, CL_LF, CL_CR, CL_SP, CL_BANG, CL_COLON, CL_AT, CL_ETC
    } byte_class_t;

    // Parser states as the line progresses; LS_ERR is the sticky error.
    typedef enum logic [4:0] {
        LS_BEGIN, LS_NICK0, LS_NICK, LS_NICKSP, LS_USER0, LS_USER, LS_USERSP,
        LS_HOST0, LS_HOST, LS_HOSTSP, LS_PFXSP, LS_CMD0, LS_CMD, LS_CMDSP,
        LS_ARG0, LS_ARG, LS_ARGSP, LS_TRAIL0, LS_TRAIL, LS_CRSP, LS_CRARG,
        LS_LF, LS_ERR
    } line_state_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    irctok_pkg::in_item_t  s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    irctok_pkg::out_item_t m_item;

    // Bytes waiting to be offered, the line under construction, and the
    // token reports the block still owes us.
    irctok_pkg::in_item_t  pending_bytes[$];
    logic [7:0]            line_buf[$];
    irctok_pkg::out_item_t token_reports[$];

    // Predictor state: mirrors the block's view of the current line.
    line_state_t  line_st     = LS_BEGIN;
    logic [9:0]   line_pos    = '0;
    logic [9:0]   field_open  = '0;
    logic [8:0]   param_total = '0;

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int ready_left   = 0;
    bit holdoff_done = 1'b0;

    irc_message_tokenizer #(
        .MAX_LEN (LINE_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic byte_class_t byte_class(logic [7:0] b);
        case (b)
            CHR_NUL:   return CL_NUL;
            CHR_LF:    return CL_LF;
            CHR_CR:    return CL_CR;
            CHR_SP:    return CL_SP;
            CHR_BANG:  return CL_BANG;
            CHR_COLON: return CL_COLON;
            CHR_AT:    return CL_AT;
            default:   return CL_ETC;
        endcase
    endfunction

    // Transition table of the line grammar; anything not listed is illegal.
    function automatic line_state_t next_line_state(line_state_t st, byte_class_t c);
        line_state_t nx;
        nx = LS_ERR;
        case (st)
            LS_BEGIN: begin
                if (c == CL_COLON) nx = LS_NICK0;
                else if (c == CL_ETC) nx = LS_CMD0;
            end
            LS_NICK0: begin
                if (c == CL_ETC) nx = LS_NICK;
            end
            LS_NICK: begin
                if (c == CL_SP) nx = LS_NICKSP;
                else if (c == CL_BANG) nx = LS_USER0;
                else if (c == CL_AT) nx = LS_HOST0;
                else if (c == CL_ETC) nx = LS_NICK;
            end
            LS_USER0: begin
                if (c == CL_ETC) nx = LS_USER;
            end
            LS_USER: begin
                if (c == CL_SP) nx = LS_USERSP;
                else if (c == CL_AT) nx = LS_HOST0;
                else if (c == CL_ETC) nx = LS_USER;
            end
            LS_HOST0: begin
                if (c inside {CL_COLON, CL_ETC}) nx = LS_HOST;
            end
            LS_HOST: begin
                if (c == CL_SP) nx = LS_HOSTSP;
                else if (c inside {CL_COLON, CL_ETC}) nx = LS_HOST;
            end
            // end of a prefix part: more spaces, or the command begins
            LS_NICKSP, LS_USERSP, LS_HOSTSP, LS_PFXSP: begin
                if (c == CL_SP) nx = LS_PFXSP;
                else if (c == CL_ETC) nx = LS_CMD0;
            end
            LS_CMD0, LS_CMD: begin
                if (c == CL_SP) nx = LS_CMDSP;
                else if (c == CL_ETC) nx = LS_CMD;
            end
            // between parameters; only after a middle one may CR follow
            LS_CMDSP, LS_ARGSP: begin
                if (c == CL_SP) nx = st;
                else if (c == CL_COLON) nx = LS_TRAIL0;
                else if (c inside {CL_BANG, CL_AT, CL_ETC}) nx = LS_ARG0;
                else if (c == CL_CR && st == LS_ARGSP) nx = LS_CRSP;
            end
            LS_ARG0, LS_ARG: begin
                if (c == CL_SP) nx = LS_ARGSP;
                else if (c inside {CL_BANG, CL_COLON, CL_AT, CL_ETC}) nx = LS_ARG;
                else if (c == CL_CR && st == LS_ARG) nx = LS_CRARG;
            end
            LS_TRAIL0, LS_TRAIL: begin
                if (c == CL_CR) nx = LS_CRARG;
                else if (c inside {CL_SP, CL_BANG, CL_COLON, CL_AT, CL_ETC}) nx = LS_TRAIL;
            end
            LS_CRSP, LS_CRARG: begin
                if (c == CL_LF) nx = LS_LF;
            end
            default: ;
        endcase
        return nx;
    endfunction

    // Advance the predictor by one accepted byte and return the report due.
    function automatic irctok_pkg::out_item_t tokenize_byte(irctok_pkg::in_item_t it);
        line_state_t                   prev_st;
        line_state_t                   next_st;
        logic [9:0]                    pos;
        logic [9:0]                    span;
        logic                          closed;
        logic [irctok_pkg::KIND_W-1:0] kind;
        irctok_pkg::out_item_t         rep;

        prev_st = line_st;
        pos     = line_pos;
        closed  = 1'b0;
        kind    = irctok_pkg::KIND_NICK;
        rep     = '0;

        // overlength pushes the line into the error state as well
        if (prev_st == LS_ERR || pos >= LINE_MAX)
            next_st = LS_ERR;
        else
            next_st = next_line_state(prev_st, byte_class(it.data_byte));

        case (next_st)
            LS_NICK0, LS_TRAIL0: field_open = pos + 10'd1;
            LS_CMD0, LS_ARG0:    field_open = pos;
            LS_USER0, LS_NICKSP: begin
                closed = 1'b1;
                kind   = irctok_pkg::KIND_NICK;
            end
            LS_USERSP: begin
                closed = 1'b1;
                kind   = irctok_pkg::KIND_USER;
            end
            // nick directly followed by '@' is still a nick
            LS_HOST0: begin
                closed = 1'b1;
                kind   = (prev_st == LS_NICK) ? irctok_pkg::KIND_NICK
                                              : irctok_pkg::KIND_USER;
            end
            LS_HOSTSP: begin
                closed = 1'b1;
                kind   = irctok_pkg::KIND_HOST;
            end
            // only the first of a run of spaces closes the field
            LS_CMDSP: begin
                if (prev_st != LS_CMDSP) begin
                    closed = 1'b1;
                    kind   = irctok_pkg::KIND_COMMAND;
                end
            end
            LS_ARGSP: begin
                if (prev_st != LS_ARGSP) begin
                    closed = 1'b1;
                    kind   = irctok_pkg::KIND_PARAM;
                end
            end
            LS_CRARG: begin
                closed = 1'b1;
                kind   = irctok_pkg::KIND_PARAM;
            end
            default: ;
        endcase

        if (closed) begin
            span             = pos - field_open;
            rep.field_valid  = 1'b1;
            rep.field_kind   = kind;
            rep.field_start  = field_open[irctok_pkg::FIELD_W-1:0];
            rep.field_length = span[irctok_pkg::FIELD_W-1:0];
            if (kind == irctok_pkg::KIND_PARAM) begin
                if (param_total != irctok_pkg::PARAM_MAX)
                    param_total = param_total + 9'd1;
                rep.param_number = param_total;
            end
            if (kind == irctok_pkg::KIND_NICK || kind == irctok_pkg::KIND_USER)
                field_open = pos + 10'd1;
        end

        line_st = next_st;
        if (line_pos < LINE_MAX)
            line_pos = line_pos + 10'd1;

        rep.message_done = it.last_byte;
        rep.message_ok   = it.last_byte && (next_st == LS_LF);
        rep.parse_error  = (next_st == LS_ERR);

        // last byte: back to the start of a fresh line
        if (it.last_byte) begin
            line_st     = LS_BEGIN;
            line_pos    = '0;
            field_open  = '0;
            param_total = '0;
        end
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Line construction
    // ------------------------------------------------------------------

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (byte_class(b) != CL_ETC);
        return b;
    endfunction

    task automatic put(logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_plain(int n);
        repeat (n) put(plain_byte());
    endtask

    task automatic put_spaces(int n);
        repeat (n) put(CHR_SP);
    endtask

    // host may carry colons (IPv6 style)
    task automatic put_host(int n);
        repeat (n) put(($urandom_range(0, 3) == 0) ? CHR_COLON : plain_byte());
    endtask

    // middle parameter: may not open with a colon, that would start a trailing one
    task automatic put_middle(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 5);
            if (sel == 0) put(CHR_BANG);
            else if (sel == 1) put(CHR_AT);
            else if (sel == 2 && i > 0) put(CHR_COLON);
            else put(plain_byte());
        end
    endtask

    task automatic put_trailing(int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(0, 7);
            case (sel)
                0:       put(CHR_SP);
                1:       put(CHR_BANG);
                2:       put(CHR_COLON);
                3:       put(CHR_AT);
                default: put(plain_byte());
            endcase
        end
    endtask

    // Hand the buffered line to the driver, last flag on its final byte.
    task automatic flush_line();
        irctok_pkg::in_item_t it;
        foreach (line_buf[i]) begin
            it.data_byte = line_buf[i];
            it.last_byte = (i == line_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        line_buf.delete();
    endtask

    // Well-formed line: optional prefix, command, params, CR LF.
    task automatic build_line();
        int  n_mid;
        bit  with_trail;
        if ($urandom_range(0, 1)) begin
            put(CHR_COLON);
            put_plain($urandom_range(1, 5));
            case ($urandom_range(0, 3))
                1: begin
                    put(CHR_BANG);
                    put_plain($urandom_range(1, 5));
                end
                2: begin
                    put(CHR_AT);
                    put_host($urandom_range(1, 6));
                end
                3: begin
                    put(CHR_BANG);
                    put_plain($urandom_range(1, 5));
                    put(CHR_AT);
                    put_host($urandom_range(1, 6));
                end
                default: ;
            endcase
            put_spaces($urandom_range(1, 3));
        end
        put_plain($urandom_range(1, 6));
        // the grammar needs at least one parameter before CR
        n_mid      = $urandom_range(0, 4);
        with_trail = (n_mid == 0) || $urandom_range(0, 1);
        repeat (n_mid) begin
            put_spaces($urandom_range(1, 3));
            put_middle($urandom_range(1, 6));
        end
        if (with_trail) begin
            put_spaces($urandom_range(1, 2));
            put(CHR_COLON);
            put_trailing($urandom_range(0, 8));
        end else if ($urandom_range(0, 2) == 0) begin
            put_spaces($urandom_range(1, 2));
        end
        put(CHR_CR);
        put(CHR_LF);
    endtask

    // Mostly clean lines; the rest corrupted, cut short, overrun or noise.
    task automatic build_random_line();
        int sel;
        int cut;
        sel = $urandom_range(0, 9);
        build_line();
        if (sel == 6) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (sel == 7) begin
            // last byte arrives mid-field
            cut = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > cut)
                void'(line_buf.pop_back());
        end else if (sel == 8) begin
            // junk after the LF
            repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
        end else if (sel == 9) begin
            line_buf.delete();
            repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
        end
    endtask

    // Many one-byte params then a trailing one, padded to the given length.
    task automatic build_long_line(int total);
        put_plain(1);
        repeat (LONG_PARAMS) begin
            put(CHR_SP);
            put_plain(1);
        end
        put(CHR_SP);
        put(CHR_COLON);
        while (line_buf.size() < total - 2)
            put_plain(1);
        put(CHR_CR);
        put(CHR_LF);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of items with random gaps, one NBA per signal per edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_item     <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                token_reports.push_back(tokenize_byte(s_item));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_bytes.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item  <= pending_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        // a quarter of bursts run straight into the next
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready runs, plus one long hold-off so the block's
    // queue fills and s_ready drops while items are still being offered
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
        end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            m_ready      <= 1'b0;
            holdoff_done <= 1'b1;
            ready_left   <= HOLDOFF_CYCLES;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            m_ready    <= ($urandom_range(0, 2) != 0);
            ready_left <= $urandom_range(0, 12);
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted result against the oldest owed report
    // ------------------------------------------------------------------
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge aclk) begin : result_check
        irctok_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (token_reports.size() == 0) begin
                $error("unexpected result item, nothing outstanding");
                fail_count = fail_count + 1;
            end else begin
                want = token_reports.pop_front();
                check_field("field_valid",  want.field_valid,  m_item.field_valid);
                check_field("field_kind",   want.field_kind,   m_item.field_kind);
                check_field("field_start",  want.field_start,  m_item.field_start);
                check_field("field_length", want.field_length, m_item.field_length);
                check_field("param_number", want.param_number, m_item.param_number);
                check_field("message_done", want.message_done, m_item.message_done);
                check_field("message_ok",   want.message_ok,   m_item.message_ok);
                check_field("parse_error",  want.parse_error,  m_item.parse_error);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run_ctrl
        int short_items;
        int line_no;

        // Directed: full prefix with doubled space after the command and a
        // middle param ending on CR; nick straight into host with an empty
        // trailing param; the byte extremes as one-byte lines.
        put_str(":a!b@c D  e");
        put(CHR_CR);
        put(CHR_LF);
        flush_line();
        put_str(":n@h X :");
        put(CHR_CR);
        put(CHR_LF);
        flush_line();
        put(8'h00);
        flush_line();
        put(8'hFF);
        flush_line();

        // Random lines; one overlong line is slipped in early and not
        // counted against the short budget.
        short_items = 0;
        line_no     = 0;
        while (short_items < RANDOM_ITEMS) begin
            if (line_no == 4) begin
                build_long_line(LINE_MAX + 8);
                flush_line();
            end
            build_random_line();
            short_items = short_items + line_buf.size();
            flush_line();
            line_no = line_no + 1;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || token_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && token_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
